FILE: rtl/abo_pkg.sv
// ----------------------------------------------------------------------------
// abo_pkg
// shared widths, constants and the divider stage record for the
// alpha-over blend pipeline
// ----------------------------------------------------------------------------
package abo_pkg;

	localparam int CH_W      = 8;   // one color or alpha channel
	localparam int PROD_W    = 16;  // 8 x 8 product, also the blend denominator
	localparam int NUM_W     = 24;  // weighted sum of one color channel
	localparam int DSH_W     = PROD_W + CH_W - 1;  // denominator shifted to the top quotient bit
	localparam int DIV_STEPS = CH_W;  // one quotient bit per stage

	localparam logic [CH_W-1:0] CHAN_MAX = 8'd255;

	// one item inside the restoring divider
	typedef struct packed {
		logic [NUM_W-1:0] rem_r;
		logic [NUM_W-1:0] rem_g;
		logic [NUM_W-1:0] rem_b;
		logic [DSH_W-1:0] dsh;
		logic [CH_W-1:0]  quot_r;
		logic [CH_W-1:0]  quot_g;
		logic [CH_W-1:0]  quot_b;
		logic [CH_W-1:0]  alpha;
	} abo_div_t;

endpackage

FILE: rtl/abo_in_if.sv
// ----------------------------------------------------------------------------
// abo_in_if
// input channel: one source and one destination pixel per item
// ----------------------------------------------------------------------------
interface abo_in_if;

	logic                    valid;
	logic                    ready;
	logic [abo_pkg::CH_W-1:0] src_red;
	logic [abo_pkg::CH_W-1:0] src_green;
	logic [abo_pkg::CH_W-1:0] src_blue;
	logic [abo_pkg::CH_W-1:0] src_alpha;
	logic [abo_pkg::CH_W-1:0] dst_red;
	logic [abo_pkg::CH_W-1:0] dst_green;
	logic [abo_pkg::CH_W-1:0] dst_blue;
	logic [abo_pkg::CH_W-1:0] dst_alpha;

	modport source (
		output valid, src_red, src_green, src_blue, src_alpha,
		output dst_red, dst_green, dst_blue, dst_alpha,
		input  ready
	);

	modport sink (
		input  valid, src_red, src_green, src_blue, src_alpha,
		input  dst_red, dst_green, dst_blue, dst_alpha,
		output ready
	);

endinterface

FILE: rtl/abo_out_if.sv
// ----------------------------------------------------------------------------
// abo_out_if
// output channel: one composited pixel per item
// ----------------------------------------------------------------------------
interface abo_out_if;

	logic                    valid;
	logic                    ready;
	logic [abo_pkg::CH_W-1:0] out_red;
	logic [abo_pkg::CH_W-1:0] out_green;
	logic [abo_pkg::CH_W-1:0] out_blue;
	logic [abo_pkg::CH_W-1:0] out_alpha;

	modport source (
		output valid, out_red, out_green, out_blue, out_alpha,
		input  ready
	);

	modport sink (
		input  valid, out_red, out_green, out_blue, out_alpha,
		output ready
	);

endinterface

FILE: rtl/abo_div_step.sv
// ----------------------------------------------------------------------------
// abo_div_step
// one registered step of the restoring divider: resolves one quotient bit
// for each of the three color lanes
// ----------------------------------------------------------------------------
module abo_div_step (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              ld,
	input  logic              vld_in,
	input  abo_pkg::abo_div_t dat_in,
	output logic              vld_s,
	output abo_pkg::abo_div_t dat_s
);

	localparam int NUM_W = abo_pkg::NUM_W;
	localparam int CH_W  = abo_pkg::CH_W;

	logic [NUM_W-1:0] dsh_ext;
	logic             ge_r;
	logic             ge_g;
	logic             ge_b;
	abo_pkg::abo_div_t nxt;

	assign dsh_ext = {1'b0, dat_in.dsh};
	assign ge_r    = dat_in.rem_r >= dsh_ext;
	assign ge_g    = dat_in.rem_g >= dsh_ext;
	assign ge_b    = dat_in.rem_b >= dsh_ext;

	always_comb begin
		nxt        = dat_in;
		nxt.rem_r  = ge_r ? dat_in.rem_r - dsh_ext : dat_in.rem_r;
		nxt.rem_g  = ge_g ? dat_in.rem_g - dsh_ext : dat_in.rem_g;
		nxt.rem_b  = ge_b ? dat_in.rem_b - dsh_ext : dat_in.rem_b;
		nxt.quot_r = {dat_in.quot_r[CH_W-2:0], ge_r};
		nxt.quot_g = {dat_in.quot_g[CH_W-2:0], ge_g};
		nxt.quot_b = {dat_in.quot_b[CH_W-2:0], ge_b};
		nxt.dsh    = dat_in.dsh >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= 1'b0;
		end else if (ld) begin
			vld_s <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			dat_s <= nxt;
		end
	end

endmodule

FILE: rtl/alpha_over_blend_unit.sv
// ----------------------------------------------------------------------------
// alpha_over_blend_unit
// source-over-destination compositing of straight-alpha pixels, exact
// integer arithmetic with truncated results
// ----------------------------------------------------------------------------
// pix_in carries one source and one destination pixel per item, pix_out one
// composited pixel; both are valid/ready channels, an item moves when both
// are high at a clock edge.
// the pipeline has ten register stages: two for the weight products and the
// per-channel sums, then eight divider steps, one quotient bit each.
// throughput is one item per clock while pix_out is ready; the divider stages
// are fully pipelined. every stage loads when it is empty or the stage after
// it moves, so bubbles close up and a stalled receiver only blocks input once
// all ten stages hold an item. a held item and its fields stay unchanged
// until taken.
// reset (arst_n low) empties the pipeline; no result is shown afterwards
// until new items arrive.
// both alphas zero gives an all-zero pixel.
// ----------------------------------------------------------------------------
module alpha_over_blend_unit (
	input  logic       clk,
	input  logic       arst_n,
	abo_in_if.sink     pix_in,
	abo_out_if.source  pix_out
);

	localparam int CH_W      = abo_pkg::CH_W;
	localparam int PROD_W    = abo_pkg::PROD_W;
	localparam int NUM_W     = abo_pkg::NUM_W;
	localparam int DSH_W     = abo_pkg::DSH_W;
	localparam int DIV_STEPS = abo_pkg::DIV_STEPS;

	// stage 1: products
	logic              v_s1;
	logic [PROD_W-1:0] ps_r_s1;
	logic [PROD_W-1:0] ps_g_s1;
	logic [PROD_W-1:0] ps_b_s1;
	logic [PROD_W-1:0] wd_s1;
	logic [CH_W-1:0]   sa_s1;
	logic [CH_W-1:0]   dr_s1;
	logic [CH_W-1:0]   dg_s1;
	logic [CH_W-1:0]   db_s1;
	logic              ld1;

	// stage 2: numerators and denominator
	logic              v_s2;
	logic [NUM_W-1:0]  num_r_s2;
	logic [NUM_W-1:0]  num_g_s2;
	logic [NUM_W-1:0]  num_b_s2;
	logic [PROD_W-1:0] den_s2;
	logic [CH_W-1:0]   alpha_s2;
	logic              ld2;

	logic [PROD_W:0]   den_c;
	logic [PROD_W:0]   den_p1;
	logic [PROD_W:0]   alpha_c;
	logic [NUM_W-1:0]  ws_r;
	logic [NUM_W-1:0]  ws_g;
	logic [NUM_W-1:0]  ws_b;

	abo_pkg::abo_div_t div_init;
	logic [DIV_STEPS-1:0] step_ld;
	logic [DIV_STEPS-1:0] step_vld;
	abo_pkg::abo_div_t    step_dat [DIV_STEPS];

	assign ld1 = !v_s1 || ld2;
	assign ld2 = !v_s2 || step_ld[0];
	assign pix_in.ready = ld1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ld1) begin
			v_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			ps_r_s1 <= PROD_W'(pix_in.src_red)   * PROD_W'(pix_in.src_alpha);
			ps_g_s1 <= PROD_W'(pix_in.src_green) * PROD_W'(pix_in.src_alpha);
			ps_b_s1 <= PROD_W'(pix_in.src_blue)  * PROD_W'(pix_in.src_alpha);
			wd_s1   <= PROD_W'(pix_in.dst_alpha)
				* PROD_W'(abo_pkg::CHAN_MAX - pix_in.src_alpha);
			sa_s1   <= pix_in.src_alpha;
			dr_s1   <= pix_in.dst_red;
			dg_s1   <= pix_in.dst_green;
			db_s1   <= pix_in.dst_blue;
		end
	end

	// x*255 as (x << 8) - x
	assign ws_r = {ps_r_s1, 8'd0} - NUM_W'(ps_r_s1);
	assign ws_g = {ps_g_s1, 8'd0} - NUM_W'(ps_g_s1);
	assign ws_b = {ps_b_s1, 8'd0} - NUM_W'(ps_b_s1);
	assign den_c = {1'b0, sa_s1, 8'd0} - (PROD_W+1)'(sa_s1) + (PROD_W+1)'(wd_s1);
	// floor(x/255) = (x+1 + ((x+1) >> 8)) >> 8 for x below 65535
	assign den_p1  = den_c + (PROD_W+1)'(1);
	assign alpha_c = den_p1 + (den_p1 >> 8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ld2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld2) begin
			num_r_s2 <= ws_r + NUM_W'(dr_s1) * NUM_W'(wd_s1);
			num_g_s2 <= ws_g + NUM_W'(dg_s1) * NUM_W'(wd_s1);
			num_b_s2 <= ws_b + NUM_W'(db_s1) * NUM_W'(wd_s1);
			den_s2   <= den_c[PROD_W-1:0];
			alpha_s2 <= alpha_c[2*CH_W-1:CH_W];
		end
	end

	// a zero denominator means a zero numerator; an all-ones divisor then
	// never subtracts and the quotient stays zero
	always_comb begin
		div_init        = '0;
		div_init.rem_r  = num_r_s2;
		div_init.rem_g  = num_g_s2;
		div_init.rem_b  = num_b_s2;
		div_init.dsh    = (den_s2 == '0) ? '1 : {den_s2, (CH_W-1)'(0)};
		div_init.alpha  = alpha_s2;
	end

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		if (k == DIV_STEPS - 1) begin : g_last
			assign step_ld[k] = !step_vld[k] || pix_out.ready;
		end else begin : g_mid
			assign step_ld[k] = !step_vld[k] || step_ld[k+1];
		end

		if (k == 0) begin : g_first
			abo_div_step u_step (
				.clk    (clk),
				.arst_n (arst_n),
				.ld     (step_ld[k]),
				.vld_in (v_s2),
				.dat_in (div_init),
				.vld_s  (step_vld[k]),
				.dat_s  (step_dat[k])
			);
		end else begin : g_next
			abo_div_step u_step (
				.clk    (clk),
				.arst_n (arst_n),
				.ld     (step_ld[k]),
				.vld_in (step_vld[k-1]),
				.dat_in (step_dat[k-1]),
				.vld_s  (step_vld[k]),
				.dat_s  (step_dat[k])
			);
		end
	end

	assign pix_out.valid     = step_vld[DIV_STEPS-1];
	assign pix_out.out_red   = step_dat[DIV_STEPS-1].quot_r;
	assign pix_out.out_green = step_dat[DIV_STEPS-1].quot_g;
	assign pix_out.out_blue  = step_dat[DIV_STEPS-1].quot_b;
	assign pix_out.out_alpha = step_dat[DIV_STEPS-1].alpha;

	// an accepted item always lands in stage 1
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		pix_in.valid && pix_in.ready |=> v_s1)
		else $error("accepted item not captured in stage 1");

	// a blocked stage 2 keeps its item
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && !step_ld[0] |=> v_s2 && $stable(num_r_s2) && $stable(den_s2))
		else $error("stage 2 item lost while stalled");

	// both alphas zero: zero numerators and zero alpha
	a_zero_den: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && den_s2 == '0 |-> alpha_s2 == '0 && num_r_s2 == '0
			&& num_g_s2 == '0 && num_b_s2 == '0)
		else $error("zero denominator with nonzero numerator or alpha");

	// the red remainder after the first divider step stays below the divisor that step used
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_vld[0] |-> step_dat[0].rem_r < {1'b0, step_dat[0].dsh, 1'b0}
			|| step_dat[0].dsh[DSH_W-1])
		else $error("quotient overflow in the first divider step");

endmodule
